// ===== sv/switch_bank_debouncer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the switch bank debouncer
// Shared forms for the concurrent checks on the block's control logic.
// ----------------------------------------------------------------------------
`ifndef SWITCH_BANK_DEBOUNCER_ASSERT_SVH
`define SWITCH_BANK_DEBOUNCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg
// Constants, types and the switch-to-pin mapping of the switch bank debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

   localparam int NUM_CHAINS   = 2;
   localparam int CHAIN_BITS   = 8;
   localparam int NUM_SW       = NUM_CHAINS * CHAIN_BITS;
   localparam int LEVEL_W      = 16;
   localparam int ACTIVE_SW    = (NUM_SW < LEVEL_W) ? NUM_SW : LEVEL_W;
   localparam int BIT_IDX_W    = $clog2(LEVEL_W);
   localparam int SW_NO_W      = 4;
   localparam int COUNT_W      = 8;
   localparam logic [COUNT_W-1:0] SETTLE_RESET = COUNT_W'(8);

   localparam logic FUNC_SCAN  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic                 hit;
      logic [BIT_IDX_W-1:0] idx;
   } sbd_pin_type;

   typedef struct packed {
      logic               query;
      logic [SW_NO_W-1:0] switch_no;
   } sbd_op_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] stable;
      logic [LEVEL_W-1:0] pending;
   } sbd_state_type;

   // Pin position of a switch. In every chain but the first the two halves
   // of the chain are swapped. Switches outside the bank give no hit.
   function automatic sbd_pin_type sw_to_pin(input logic [SW_NO_W-1:0] sw);
      sbd_pin_type res;
      int          s;
      int          pos;
      int          b;
      res = '0;
      for (int c = 0; c < NUM_CHAINS; c++) begin
         for (int p = 0; p < CHAIN_BITS; p++) begin
            s   = c * CHAIN_BITS + p;
            pos = (c != 0) ? ((p + CHAIN_BITS / 2) % CHAIN_BITS) : p;
            b   = c * CHAIN_BITS + pos;
            if ((int'(sw) == s) && (b < LEVEL_W)) begin
               res.hit = 1'b1;
               res.idx = BIT_IDX_W'(b);
            end
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sbd_switch_cell.sv =====
// ----------------------------------------------------------------------------
// sbd_switch_cell
// Settle counter of one switch: reloads on a level change, counts down
// otherwise, and flags expiry on the scan that brings it to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbd_switch_cell import sbd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               scan_commit,
   input  wire logic               sample_bit,
   input  wire logic               prev_bit,
   input  wire logic [COUNT_W-1:0] settle_count,
   output logic                    expire
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               moved;

   assign moved  = sample_bit != prev_bit;
   assign expire = !moved && (count_ff == COUNT_W'(1));

   always_comb begin
      priority if (moved) begin
         count_in = settle_count;
      end else if (count_ff != '0) begin
         count_in = count_ff - COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (scan_commit) begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sbd_flags.sv =====
// ----------------------------------------------------------------------------
// sbd_flags
// Previous sample, debounced levels and pending change flags, with the
// scan update and the query read-and-clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbd_flags import sbd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               commit,
   input  wire sbd_op_type         op,
   input  wire logic [LEVEL_W-1:0] sample,
   input  wire logic [LEVEL_W-1:0] expire,
   output logic [LEVEL_W-1:0]      prev_sample,
   output sbd_state_type           state_cur,
   output sbd_state_type           state_next,
   output logic                    query_level,
   output logic                    query_changed
);

   logic [LEVEL_W-1:0] prev_ff;
   logic [LEVEL_W-1:0] prev_in;
   sbd_state_type      state_ff;
   sbd_pin_type        pin;

   assign pin = sw_to_pin(op.switch_no);

   always_comb begin
      state_next    = state_ff;
      prev_in       = prev_ff;
      query_level   = 1'b0;
      query_changed = 1'b0;
      if (op.query) begin
         if (pin.hit) begin
            query_level   = state_ff.stable[pin.idx];
            query_changed = state_ff.pending[pin.idx];
            state_next.pending[pin.idx] = 1'b0;
         end
      end else begin
         // An expiring counter sets the flag even if the level is unchanged.
         state_next.stable  = (state_ff.stable & ~expire) | (sample & expire);
         state_next.pending = state_ff.pending | expire;
         prev_in            = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         state_ff <= '0;
      end else if (commit) begin
         prev_ff  <= prev_in;
         state_ff <= state_next;
      end
   end

   assign prev_sample = prev_ff;
   assign state_cur   = state_ff;

endmodule

`default_nettype wire

// ===== sv/switch_bank_debouncer.sv =====
// ----------------------------------------------------------------------------
// switch_bank_debouncer
// Counter-based debouncer for a bank of sixteen active-low switches.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one item per transfer: a scan (req_func low)
//   with the raw pin levels, or a query (req_func high) of one switch.
//   Each item yields exactly one rsp_ transfer with the debounced levels and
//   pending change flags after the item, plus the queried switch's level and
//   change flag (zero for a scan). A query clears that switch's flag.
//   A request is taken into the input register and moves on to the result
//   register, which drives rsp_valid, once that one is empty or being read.
//   Throughput is one item per cycle while the receiver does not stall: on a
//   scan the sixteen settle counters all update in parallel as the item
//   moves from the input register to the result register.
//   When the receiver stalls, the result register holds and the input
//   register fills; req_ready drops only when both are occupied.
//   csr_wr_en writes settle_count; write it only while the block is idle.
//   Reset (synchronous, active high) empties both registers, clears the
//   counters, levels and flags, and sets settle_count to 8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "switch_bank_debouncer_assert.svh"

module switch_bank_debouncer import sbd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_func,
   input  wire logic [LEVEL_W-1:0] req_raw_levels,
   input  wire logic [SW_NO_W-1:0] req_switch_no,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [LEVEL_W-1:0]      rsp_stable_levels,
   output logic [LEVEL_W-1:0]      rsp_changed_flags,
   output logic                    rsp_query_level,
   output logic                    rsp_query_changed
);

   logic [COUNT_W-1:0] settle_ff;

   logic               in_valid_ff;
   logic               in_func_ff;
   logic [LEVEL_W-1:0] in_raw_ff;
   logic [SW_NO_W-1:0] in_sw_ff;

   logic               out_valid_ff;
   logic [LEVEL_W-1:0] out_stable_ff;
   logic [LEVEL_W-1:0] out_pending_ff;
   logic               out_qlevel_ff;
   logic               out_qchanged_ff;

   logic               advance;
   logic               scan_commit;
   logic [LEVEL_W-1:0] sample;
   logic [LEVEL_W-1:0] prev_sample;
   logic [LEVEL_W-1:0] expire;
   sbd_op_type         op;
   sbd_state_type      state_cur;
   sbd_state_type      state_next;
   logic               query_level;
   logic               query_changed;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign scan_commit = advance && (in_func_ff == FUNC_SCAN);
   assign sample      = ~in_raw_ff;
   assign op.query    = in_func_ff == FUNC_QUERY;
   assign op.switch_no = in_sw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
      end else if (csr_wr_en) begin
         settle_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_raw_ff  <= req_raw_levels;
         in_sw_ff   <= req_switch_no;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < LEVEL_W; gi++) begin : g_sw
         if (gi < ACTIVE_SW) begin : g_cell
            sbd_switch_cell u_cell (
               .clock        (clock),
               .reset        (reset),
               .scan_commit  (scan_commit),
               .sample_bit   (sample[gi]),
               .prev_bit     (prev_sample[gi]),
               .settle_count (settle_ff),
               .expire       (expire[gi])
            );
         end else begin : g_none
            assign expire[gi] = 1'b0;
         end
      end
   endgenerate

   sbd_flags u_flags (
      .clock         (clock),
      .reset         (reset),
      .commit        (advance),
      .op            (op),
      .sample        (sample),
      .expire        (expire),
      .prev_sample   (prev_sample),
      .state_cur     (state_cur),
      .state_next    (state_next),
      .query_level   (query_level),
      .query_changed (query_changed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_stable_ff   <= state_next.stable;
         out_pending_ff  <= state_next.pending;
         out_qlevel_ff   <= query_level;
         out_qchanged_ff <= query_changed;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_stable_levels = out_stable_ff;
   assign rsp_changed_flags = out_pending_ff;
   assign rsp_query_level   = out_qlevel_ff;
   assign rsp_query_changed = out_qchanged_ff;

   // A scan transfer always reports no query bits.
   `SBD_ASSERT_NEXT(a_scan_no_query, clock, reset, scan_commit,
      !rsp_query_level && !rsp_query_changed, "scan result carries query bits")

   // A query never moves a debounced level.
   `SBD_ASSERT_NEXT(a_query_keeps_levels, clock, reset, advance && op.query,
      state_cur.stable == $past(state_cur.stable), "query changed a stable level")

   // A query can only clear pending flags, never raise one.
   `SBD_ASSERT_NEXT(a_query_no_new_flag, clock, reset, advance && op.query,
      (state_cur.pending & ~$past(state_cur.pending)) == '0,
      "query raised a pending flag")

   // A held item in the input register is not lost while the output stalls.
   `SBD_ASSERT_SAME(a_full_not_ready, clock, reset, in_valid_ff && !advance,
      !req_ready, "input register overwritten while stalled")

endmodule

`default_nettype wire
